// ===== src/assert_macros.svh =====
// Concurrent assertion helpers; empty under SYNTH.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check on every clock edge, suspended while reset is high.
`define USD_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failure");

// Check on every clock edge, reset included.
`define USD_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("assertion failure");

`else

`define USD_ASSERT(name, clk, rst, prop)
`define USD_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

// ===== src/usd_pkg.sv =====
`default_nettype none
package usd_pkg;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] MASK_6B = 8'h01;
  localparam logic [7:0] MASK_5B = 8'h03;
  localparam logic [7:0] MASK_4B = 8'h07;
  localparam logic [7:0] MASK_3B = 8'h0F;
  localparam logic [7:0] MASK_2B = 8'h1F;

  typedef enum logic [2:0] {
    OP_CHAR = 3'd0,
    OP_ERR  = 3'd1,
    OP_LEAD = 3'd2,
    OP_CONT = 3'd3,
    OP_LAST = 3'd4
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [6:0] payload;
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] remaining_next;
  } cls_t;

  function automatic cls_t classify(input logic [7:0] b, input logic mode,
                                    input logic [2:0] remaining);
    cls_t       c;
    logic [7:0] m;
    c.op.kind         = OP_CHAR;
    c.op.payload      = '0;
    c.remaining_next  = '0;
    m                 = '0;
    if (remaining != 3'd0) begin
      c.remaining_next = remaining - 3'd1;
      c.op.kind        = (remaining == 3'd1) ? OP_LAST : OP_CONT;
      c.op.payload     = {1'b0, b[5:0]};
    end else if (!b[7]) begin
      c.op.kind    = OP_CHAR;
      c.op.payload = b[6:0];
    end else if (!b[6]) begin
      c.op.kind = OP_ERR;
    end else begin
      c.op.kind = OP_LEAD;
      if (mode && b[5]) begin
        m = MASK_3B;
        c.remaining_next = 3'd2;
      end else if (b[7:2] == 6'h3F) begin
        m = MASK_6B;
        c.remaining_next = 3'd5;
      end else if (b[7:3] == 5'h1F) begin
        m = MASK_5B;
        c.remaining_next = 3'd4;
      end else if (b[7:4] == 4'hF) begin
        m = MASK_4B;
        c.remaining_next = 3'd3;
      end else if (b[5]) begin
        m = MASK_3B;
        c.remaining_next = 3'd2;
      end else begin
        m = MASK_2B;
        c.remaining_next = 3'd1;
      end
      c.op.payload = 7'(b & m);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== src/usd_front.sv =====
`default_nettype none
module usd_front (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        mode,
  input  wire logic        push,
  input  wire logic        full,
  input  wire logic [7:0]  data_byte,
  output usd_pkg::op_t     op,
  output logic             op_push
);

  logic [2:0]    remaining;
  usd_pkg::cls_t cls;

  assign cls     = usd_pkg::classify(data_byte, mode, remaining);
  assign op      = cls.op;
  assign op_push = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (op_push) begin
      remaining <= cls.remaining_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/usd_queue.sv =====
`default_nettype none
module usd_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr,
  input  usd_pkg::op_t     wr_op,
  output logic             full,
  input  wire logic        rd,
  output usd_pkg::op_t     rd_op,
  output logic             valid
);

  usd_pkg::op_t                entries [usd_pkg::QDEPTH];
  logic [usd_pkg::QPTR_W-1:0]  wptr;
  logic [usd_pkg::QPTR_W-1:0]  rptr;
  logic [usd_pkg::QCNT_W-1:0]  count;
  logic                        do_wr;
  logic                        do_rd;

  assign full  = (count == usd_pkg::QCNT_W'(usd_pkg::QDEPTH));
  assign valid = (count != '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && valid;
  assign rd_op = entries[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wptr] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == usd_pkg::QPTR_W'(usd_pkg::QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == usd_pkg::QPTR_W'(usd_pkg::QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/usd_back.sv =====
`default_nettype none
module usd_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        op_valid,
  input  usd_pkg::op_t     op,
  output logic             op_pop,
  input  wire logic        pop,
  output logic             out_valid,
  output logic [30:0]      code_point,
  output logic             error
);

  logic [30:0] accumulator;
  logic [30:0] shifted;
  logic        emits;
  logic        out_take;

  assign shifted  = {accumulator[24:0], op.payload[5:0]};
  assign out_take = pop && out_valid;

  always_comb begin
    case (op.kind)
      usd_pkg::OP_CHAR,
      usd_pkg::OP_ERR,
      usd_pkg::OP_LAST: emits = 1'b1;
      default:          emits = 1'b0;
    endcase
  end

  assign op_pop = op_valid && (!emits || !out_valid || out_take);

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
    end else if (op_pop) begin
      case (op.kind)
        usd_pkg::OP_LEAD: accumulator <= 31'(op.payload);
        usd_pkg::OP_CONT,
        usd_pkg::OP_LAST: accumulator <= shifted;
        default:          accumulator <= accumulator;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op_pop && emits) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop && emits) begin
      case (op.kind)
        usd_pkg::OP_CHAR: begin
          code_point <= 31'(op.payload);
          error      <= 1'b0;
        end
        usd_pkg::OP_LAST: begin
          code_point <= shifted;
          error      <= 1'b0;
        end
        default: begin
          code_point <= '0;
          error      <= 1'b1;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/utf8_stream_decoder_core.sv =====
// Channel   Handshake          Payload
// -------   ----------------   ----------------------------
// input     push / full        data_byte[7:0]
// result    empty / pop        code_point[30:0], error
// config    cfg_write          cfg_data (sixteen-bit mode)
//
// One byte per cycle while the op queue is not full. A byte is classified
// into a two-entry op queue, then applied to the accumulator and the output
// register. The single output register sets the limit: while it holds an
// unread result, ops that emit wait in the queue.
// Synchronous active-high reset empties both sides and clears the state.
`default_nettype none
`include "assert_macros.svh"
module utf8_stream_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [30:0]      code_point,
  output logic             error,
  input  wire logic        cfg_write,
  input  wire logic        cfg_data
);

  logic         sixteen_bit_mode;
  usd_pkg::op_t f_op;
  logic         f_push;
  usd_pkg::op_t q_op;
  logic         q_valid;
  logic         q_pop;
  logic         out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      sixteen_bit_mode <= 1'b0;
    end else if (cfg_write) begin
      sixteen_bit_mode <= cfg_data;
    end
  end

  usd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .mode      (sixteen_bit_mode),
    .push      (push),
    .full      (full),
    .data_byte (data_byte),
    .op        (f_op),
    .op_push   (f_push)
  );

  usd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (f_push),
    .wr_op (f_op),
    .full  (full),
    .rd    (q_pop),
    .rd_op (q_op),
    .valid (q_valid)
  );

  usd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .op_valid   (q_valid),
    .op         (q_op),
    .op_pop     (q_pop),
    .pop        (pop),
    .out_valid  (out_valid),
    .code_point (code_point),
    .error      (error)
  );

  assign empty = !out_valid;

  `USD_ASSERT(a_err_zero_cp, clk, rst, (!empty && error) |-> (code_point == '0))
  `USD_ASSERT(a_last_emits, clk, rst, (q_pop && q_op.kind == usd_pkg::OP_LAST) |=> !empty)
  `USD_ASSERT(a_reset_empty, clk, rst, $past(rst) |-> (empty && !full))

endmodule
`default_nettype wire
